@@ src/lpht_pkg.sv @@
// shared types and constants for the linear probing hash table
`timescale 1ns / 1ps

package lpht_pkg;

  localparam int KEY_W      = 16;
  localparam int REQ_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int SLOT_IDX_W = 4;

  localparam int DEF_SLOTS    = 16;
  localparam int DEF_KEY_BITS = 16;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STS_FULL      = 2'd2;

  typedef struct packed {
    logic load;
    logic clear;
    logic mod_step;
    logic probe_init;
    logic probe;
    logic commit;
  } lpht_cmd_t;

  typedef struct packed {
    logic mod_done;
    logic last_slot;
    logic done;
    logic out_free;
  } lpht_sts_t;

endpackage

@@ src/linear_probe_hash_table.sv @@
// Open-addressing hash table with linear probing over SLOTS slots of KEY_BITS-bit keys.
// After reset the block clears every slot, one per cycle, before in_ready rises. A request
// is transferred, set up, then reads the slot memory slot by slot from its home slot; the
// last read is checked and the result committed. A search or delete of an absent key, or an
// insert into a full table, reads every slot; a request ends early when its slot is found.
// When SLOTS is not a power of two the home slot comes from a reciprocal multiplication:
// product, quotient times SLOTS, then subtract back. The next request is taken while a
// result waits in the output register.
`timescale 1ns / 1ps

module linear_probe_hash_table #(
  parameter int SLOTS    = lpht_pkg::DEF_SLOTS,
  parameter int KEY_BITS = lpht_pkg::DEF_KEY_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lpht_pkg::REQ_W-1:0]      in_req_type,
  input  logic [lpht_pkg::KEY_W-1:0]      in_key,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lpht_pkg::STATUS_W-1:0]   out_status,
  output logic [lpht_pkg::SLOT_IDX_W-1:0] out_slot_index
);

  lpht_pkg::lpht_cmd_t cmd;
  lpht_pkg::lpht_sts_t sts;

  lpht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lpht_dp #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_req_type    (in_req_type),
    .in_key         (in_key),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_slot_index (out_slot_index)
  );

endmodule

@@ src/lpht_ctrl.sv @@
// controller state machine: clear pass, request load, key reduction, probe and commit
`timescale 1ns / 1ps

module lpht_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lpht_pkg::lpht_sts_t sts,
  output lpht_pkg::lpht_cmd_t cmd
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_MOD   = 2'd2;
  localparam logic [1:0] S_PROBE = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.last_slot) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (sts.mod_done) begin
          cmd.probe_init = 1'b1;
          state_nxt      = S_PROBE;
        end else begin
          cmd.mod_step = 1'b1;
        end
      end
      S_PROBE: begin
        if (sts.done) begin
          if (sts.out_free) begin
            cmd.commit = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else begin
          cmd.probe = 1'b1;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ src/lpht_dp.sv @@
// datapath: slot memory, key remainder unit, probe pipeline and result register
`timescale 1ns / 1ps

module lpht_dp #(
  parameter int SLOTS    = lpht_pkg::DEF_SLOTS,
  parameter int KEY_BITS = lpht_pkg::DEF_KEY_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lpht_pkg::lpht_cmd_t                cmd,
  output lpht_pkg::lpht_sts_t                sts,
  input  logic [lpht_pkg::REQ_W-1:0]         in_req_type,
  input  logic [lpht_pkg::KEY_W-1:0]         in_key,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [lpht_pkg::STATUS_W-1:0]      out_status,
  output logic [lpht_pkg::SLOT_IDX_W-1:0]    out_slot_index
);

  localparam int IDX_W     = $clog2(SLOTS);
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int BC_W      = 2;
  localparam int MOD_STEPS = 3;
  localparam int WORD_W    = KEY_BITS + 1;
  localparam int SH        = KEY_BITS + IDX_W;
  localparam int PROD_W    = 2 * KEY_BITS + 1;
  localparam bit SLOTS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);
  localparam longint unsigned RECIP_L =
    ((64'd1 << SH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
  localparam logic [KEY_BITS:0] RECIP = (KEY_BITS+1)'(RECIP_L);

  logic [WORD_W-1:0] mem [SLOTS];

  logic [lpht_pkg::REQ_W-1:0] req_r;
  logic [KEY_BITS-1:0]        key_r;
  logic [PROD_W-1:0]          prod_r;
  logic [KEY_BITS-1:0]        qs_r;
  logic [BC_W-1:0]            bitcnt_r;
  logic [IDX_W-1:0]           rem_r;
  logic [IDX_W-1:0]           rem_nxt;
  logic [IDX_W-1:0]           ptr_r;
  logic [IDX_W-1:0]           ptr_nxt;
  logic [CNT_W-1:0]           iss_r;
  logic                       chk_v_r;
  logic [IDX_W-1:0]           chk_pos_r;
  logic [WORD_W-1:0]          rd_r;
  logic                       out_valid_r;
  logic [lpht_pkg::STATUS_W-1:0]   out_status_r;
  logic [lpht_pkg::SLOT_IDX_W-1:0] out_slot_r;

  logic [KEY_BITS+lpht_pkg::KEY_W-1:0] in_key_ext;
  logic [KEY_BITS-1:0]                 key_msk;
  logic [KEY_BITS+IDX_W-1:0]           key_msk_ext;
  logic                                issue;
  logic                                is_ins;
  logic                                is_find;
  logic                                hit;
  logic                                exhausted;
  logic [IDX_W+lpht_pkg::SLOT_IDX_W-1:0] pos_ext;
  logic                                mem_we;
  logic [IDX_W-1:0]                    mem_wa;
  logic [WORD_W-1:0]                   mem_wd;

  assign in_key_ext  = {{KEY_BITS{1'b0}}, in_key};
  assign key_msk     = in_key_ext[KEY_BITS-1:0];
  assign key_msk_ext = {{IDX_W{1'b0}}, key_msk};

  // home slot: low key bits when SLOTS is a power of two, else quotient by reciprocal multiply, then subtract back
  always_comb begin
    rem_nxt = rem_r;
    if (cmd.load) begin
      rem_nxt = SLOTS_POW2 ? key_msk_ext[IDX_W-1:0] : '0;
    end else if (cmd.mod_step && (bitcnt_r == BC_W'(MOD_STEPS - 1))) begin
      rem_nxt = IDX_W'(key_r - qs_r);
    end
  end

  assign is_ins  = (req_r == lpht_pkg::REQ_INSERT);
  assign is_find = (req_r == lpht_pkg::REQ_SEARCH) || (req_r == lpht_pkg::REQ_DELETE);

  assign hit = chk_v_r &&
               ((is_ins && !rd_r[KEY_BITS]) ||
                (is_find && rd_r[KEY_BITS] && (rd_r[KEY_BITS-1:0] == key_r)));

  assign exhausted = (iss_r == CNT_W'(SLOTS)) && !chk_v_r;
  assign issue     = cmd.probe && (iss_r != CNT_W'(SLOTS));

  always_comb begin
    if (ptr_r == IDX_W'(SLOTS - 1)) begin
      ptr_nxt = '0;
    end else begin
      ptr_nxt = ptr_r + 1'b1;
    end
  end

  always_comb begin
    sts.mod_done  = SLOTS_POW2 || (bitcnt_r == BC_W'(MOD_STEPS));
    sts.last_slot = (ptr_r == IDX_W'(SLOTS - 1));
    sts.done      = hit || exhausted || (!is_ins && !is_find);
    sts.out_free  = !out_valid_r || out_ready;
  end

  // request registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req_type;
      key_r <= key_msk;
    end
    if (cmd.mod_step && (bitcnt_r == BC_W'(0))) begin
      prod_r <= PROD_W'(key_r) * PROD_W'(RECIP);
    end
    if (cmd.mod_step && (bitcnt_r == BC_W'(1))) begin
      qs_r <= KEY_BITS'(prod_r >> SH) * KEY_BITS'(SLOTS);
    end
    rem_r <= rem_nxt;
    if (issue) begin
      chk_pos_r <= ptr_r;
    end
  end

  // probe control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r    <= '0;
      iss_r    <= '0;
      chk_v_r  <= 1'b0;
      bitcnt_r <= '0;
    end else begin
      if (cmd.load) begin
        bitcnt_r <= '0;
      end else if (cmd.mod_step) begin
        bitcnt_r <= bitcnt_r + 1'b1;
      end
      if (cmd.clear) begin
        ptr_r <= ptr_nxt;
      end else if (cmd.probe_init) begin
        ptr_r   <= rem_r;
        iss_r   <= '0;
        chk_v_r <= 1'b0;
      end else if (cmd.probe) begin
        chk_v_r <= issue;
        if (issue) begin
          ptr_r <= ptr_nxt;
          iss_r <= iss_r + 1'b1;
        end
      end else if (cmd.commit) begin
        chk_v_r <= 1'b0;
      end
    end
  end

  // slot memory, valid flag on top of the key
  assign mem_we = cmd.clear || (cmd.commit && hit && (is_ins || (req_r == lpht_pkg::REQ_DELETE)));
  assign mem_wa = cmd.clear ? ptr_r : chk_pos_r;
  assign mem_wd = cmd.clear ? '0 : {is_ins, key_r};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (issue) begin
      rd_r <= mem[ptr_r];
    end
  end

  // result register
  assign pos_ext = {{lpht_pkg::SLOT_IDX_W{1'b0}}, chk_pos_r};

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (hit) begin
        out_status_r <= lpht_pkg::STS_OK;
        out_slot_r   <= pos_ext[lpht_pkg::SLOT_IDX_W-1:0];
      end else begin
        out_status_r <= is_ins ? lpht_pkg::STS_FULL : lpht_pkg::STS_NOT_FOUND;
        out_slot_r   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_index = out_slot_r;

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("result committed over a pending transfer");

  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result not presented");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= IDX_W'(SLOTS - 1))
    else $error("probe pointer beyond last slot");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    iss_r <= CNT_W'(SLOTS))
    else $error("more probes issued than slots");

endmodule

@@ test/tb.sv @@
// self-checking testbench for the linear probing hash table: directed table, then random traffic
`timescale 1ns / 1ps

module tb;

  localparam int SLOTS      = lpht_pkg::DEF_SLOTS;
  localparam int KEY_BITS   = lpht_pkg::DEF_KEY_BITS;
  localparam int RAND_ITEMS = 450;
  localparam int DIR_ROWS   = 26;
  localparam int HOLD_AT    = 120;
  localparam int HOLD_LEN   = 150;
  localparam int DRAIN_AT   = 225;
  localparam int TAIL_WAIT  = 3 * (SLOTS + 3);
  localparam int LIMIT      = 200000;

  localparam logic [lpht_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef logic [lpht_pkg::REQ_W-1:0]      req_t;
  typedef logic [lpht_pkg::KEY_W-1:0]      key_t;
  typedef logic [lpht_pkg::STATUS_W-1:0]   status_t;
  typedef logic [lpht_pkg::SLOT_IDX_W-1:0] slot_t;

  typedef struct packed {
    status_t status;
    slot_t   slot;
  } result_t;

  typedef struct packed {
    req_t    req;
    key_t    key;
    logic    typed;
    status_t status;
    slot_t   slot;
  } dir_row_t;

  logic    clk = 1'b0;
  logic    rst_n;
  logic    in_valid;
  logic    in_ready;
  req_t    in_req_type;
  key_t    in_key;
  logic    out_valid;
  logic    out_ready;
  status_t out_status;
  slot_t   out_slot_index;

  key_t    slot_keys_model [SLOTS];
  logic    slot_used_model [SLOTS];
  result_t expected_results [$];
  key_t    live_keys [$];

  int err_count = 0;
  int cycle_count = 0;
  int rx_count = 0;
  int burst_left = 0;
  int req_seen [4] = '{0, 0, 0, 0};
  int status_seen [3] = '{0, 0, 0};

  // directed rows: typed expectations only where obvious, the rest go through the predictor
  dir_row_t dir_rows [DIR_ROWS] = '{
    {lpht_pkg::REQ_SEARCH, 16'h0000, 1'b1, lpht_pkg::STS_NOT_FOUND, 4'd0},
    {lpht_pkg::REQ_DELETE, 16'hFFFF, 1'b1, lpht_pkg::STS_NOT_FOUND, 4'd0},
    {REQ_UNUSED,           16'hFFFF, 1'b1, lpht_pkg::STS_NOT_FOUND, 4'd0},
    {lpht_pkg::REQ_INSERT, 16'h0000, 1'b1, lpht_pkg::STS_OK,        4'd0},
    {lpht_pkg::REQ_INSERT, 16'hFFFF, 1'b1, lpht_pkg::STS_OK,        4'd15},
    {lpht_pkg::REQ_INSERT, 16'h0010, 1'b0, lpht_pkg::STS_OK,        4'd0},
    {lpht_pkg::REQ_INSERT, 16'h001F, 1'b0, lpht_pkg::STS_OK,        4'd0},
    {lpht_pkg::REQ_SEARCH, 16'h001F, 1'b0, lpht_pkg::STS_OK,        4'd0},
    {lpht_pkg::REQ_DELETE, 16'h0010, 1'b0, lpht_pkg::STS_OK,        4'd0},
    {lpht_pkg::REQ_SEARCH, 16'h001F, 1'b0, lpht_pkg::STS_OK,        4'd0},
    {lpht_pkg::REQ_INSERT, 16'h0000, 1'b0, lpht_pkg::STS_OK,        4'd0},
    {lpht_pkg::REQ_SEARCH, 16'h0000, 1'b0, lpht_pkg::STS_OK,        4'd0},
    {lpht_pkg::REQ_INSERT, 16'h8003, 1'b0, lpht_pkg::STS_OK,        4'd0},
    {lpht_pkg::REQ_INSERT, 16'h4004, 1'b0, lpht_pkg::STS_OK,        4'd0},
    {lpht_pkg::REQ_INSERT, 16'h2005, 1'b0, lpht_pkg::STS_OK,        4'd0},
    {lpht_pkg::REQ_INSERT, 16'h1006, 1'b0, lpht_pkg::STS_OK,        4'd0},
    {lpht_pkg::REQ_INSERT, 16'h0807, 1'b0, lpht_pkg::STS_OK,        4'd0},
    {lpht_pkg::REQ_INSERT, 16'h0408, 1'b0, lpht_pkg::STS_OK,        4'd0},
    {lpht_pkg::REQ_INSERT, 16'h0209, 1'b0, lpht_pkg::STS_OK,        4'd0},
    {lpht_pkg::REQ_INSERT, 16'h010A, 1'b0, lpht_pkg::STS_OK,        4'd0},
    {lpht_pkg::REQ_INSERT, 16'h008B, 1'b0, lpht_pkg::STS_OK,        4'd0},
    {lpht_pkg::REQ_INSERT, 16'h004C, 1'b0, lpht_pkg::STS_OK,        4'd0},
    {lpht_pkg::REQ_INSERT, 16'h002D, 1'b0, lpht_pkg::STS_OK,        4'd0},
    {lpht_pkg::REQ_INSERT, 16'h001E, 1'b0, lpht_pkg::STS_OK,        4'd0},
    {lpht_pkg::REQ_INSERT, 16'hAAAA, 1'b1, lpht_pkg::STS_FULL,      4'd0},
    {lpht_pkg::REQ_SEARCH, 16'h5555, 1'b1, lpht_pkg::STS_NOT_FOUND, 4'd0}
  };

  linear_probe_hash_table #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_key         (in_key),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_slot_index (out_slot_index)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // table update and expected result for one accepted request
  function automatic result_t apply_request(input req_t req, input key_t key);
    result_t res;
    key_t    km;
    int      home;
    int      pos;
    logic    done;
    km   = key & key_t'((32'd1 << KEY_BITS) - 1);
    home = int'(km) % SLOTS;
    done = 1'b0;
    res  = {lpht_pkg::STS_NOT_FOUND, slot_t'(0)};
    if (req == lpht_pkg::REQ_INSERT) begin
      res.status = lpht_pkg::STS_FULL;
      for (int n = 0; n < SLOTS; n++) begin
        pos = (home + n) % SLOTS;
        if (!done && !slot_used_model[pos]) begin
          slot_used_model[pos] = 1'b1;
          slot_keys_model[pos] = km;
          res  = {lpht_pkg::STS_OK, slot_t'(pos)};
          done = 1'b1;
        end
      end
    end else if (req == lpht_pkg::REQ_SEARCH || req == lpht_pkg::REQ_DELETE) begin
      for (int n = 0; n < SLOTS; n++) begin
        pos = (home + n) % SLOTS;
        if (!done && slot_used_model[pos] && slot_keys_model[pos] == km) begin
          res  = {lpht_pkg::STS_OK, slot_t'(pos)};
          done = 1'b1;
          if (req == lpht_pkg::REQ_DELETE) slot_used_model[pos] = 1'b0;
        end
      end
    end
    return res;
  endfunction

  // offer one request in bursts with gaps, return once the transfer happened
  task automatic send_request(input req_t req, input key_t key, output result_t res);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_key      <= key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = apply_request(req, key);
    req_seen[req]++;
  endtask

  task automatic wait_drained;
    in_valid   <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic key_t fresh_key;
    if ($urandom_range(0, 1))
      return key_t'($urandom);
    // four high patterns over a random low nibble, so four keys share each home slot
    return {4'($urandom_range(0, 3)), 8'h00, 4'($urandom)};
  endfunction

  // result side: check transfers, stall on a rotating pattern, one long hold-off
  initial begin
    result_t expd;
    logic    nxt;
    int      hold_left;
    logic    held;
    hold_left = 0;
    held      = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        rx_count++;
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer: status %0d slot %0d", out_status, out_slot_index);
          err_count++;
        end else begin
          expd = expected_results.pop_front();
          if (out_status !== expd.status) begin
            $error("out_status: expected %0d, got %0d", expd.status, out_status);
            err_count++;
          end
          if (out_slot_index !== expd.slot) begin
            $error("out_slot_index: expected %0d, got %0d", expd.slot, out_slot_index);
            err_count++;
          end
          if (out_status == lpht_pkg::STS_OK || out_status == lpht_pkg::STS_NOT_FOUND ||
              out_status == lpht_pkg::STS_FULL)
            status_seen[out_status]++;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b0;
      end else if (!held && rx_count >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_LEN;
        nxt       = 1'b0;
      end else begin
        case ((cycle_count >> 6) % 8)
          0, 1:    nxt = 1'b1;
          2, 3:    nxt = 1'($urandom_range(0, 1));
          4:       nxt = (cycle_count % 4 == 0);
          5:       nxt = ((cycle_count >> 2) % 2 == 1);
          default: nxt = ($urandom_range(0, 4) != 0);
        endcase
      end
      out_ready <= nxt;
    end
  end

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("run timed out after %0d cycles", LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    dir_row_t row;
    result_t  res;
    req_t     req;
    key_t     key;
    int       pick;
    int       roll;
    logic     heavy_insert;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_req_type <= lpht_pkg::REQ_INSERT;
    in_key      <= '0;
    for (int s = 0; s < SLOTS; s++) begin
      slot_keys_model[s] = '0;
      slot_used_model[s] = 1'b0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_request(row.req, row.key, res);
      if (row.typed) res = {row.status, row.slot};
      expected_results.push_back(res);
    end
    wait_drained();

    heavy_insert = 1'b1;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 40 == 0) heavy_insert = ~heavy_insert;
      if (i == DRAIN_AT) wait_drained();
      roll = $urandom_range(0, 19);
      if (heavy_insert)
        req = (roll < 11) ? lpht_pkg::REQ_INSERT : (roll < 15) ? lpht_pkg::REQ_SEARCH :
              (roll < 19) ? lpht_pkg::REQ_DELETE : REQ_UNUSED;
      else
        req = (roll < 3) ? lpht_pkg::REQ_INSERT : (roll < 9) ? lpht_pkg::REQ_SEARCH :
              (roll < 19) ? lpht_pkg::REQ_DELETE : REQ_UNUSED;
      if (req == lpht_pkg::REQ_INSERT || live_keys.size() == 0 ||
          $urandom_range(0, 3) == 0) begin
        key = fresh_key();
      end else begin
        pick = $urandom_range(0, live_keys.size() - 1);
        key  = live_keys[pick];
        if (req == lpht_pkg::REQ_DELETE) live_keys.delete(pick);
      end
      if (req == lpht_pkg::REQ_INSERT) begin
        live_keys.push_back(key);
        if (live_keys.size() > 32) void'(live_keys.pop_front());
      end
      send_request(req, key, res);
      expected_results.push_back(res);
    end

    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk);

    $display("requests: %0d insert, %0d search, %0d delete, %0d unused code",
             req_seen[lpht_pkg::REQ_INSERT], req_seen[lpht_pkg::REQ_SEARCH],
             req_seen[lpht_pkg::REQ_DELETE], req_seen[REQ_UNUSED]);
    $display("results checked: %0d (%0d ok, %0d not found, %0d full), %0d cycles",
             rx_count, status_seen[lpht_pkg::STS_OK], status_seen[lpht_pkg::STS_NOT_FOUND],
             status_seen[lpht_pkg::STS_FULL], cycle_count);
    if (err_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
